FILE: hdl/ptsp_pkg.sv
// Shared types, constants and the arctangent table for the pixel-to-servo pulse block.
// No dependencies; used by every module in this folder.
package ptsp_pkg;

    // Default parameter values.
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int PIXEL_BITS_DEF    = 12;

    // Datapath widths.
    localparam int CORDIC_W = 44;   // holds Q16.24 tangent growth plus gain, signed
    localparam int Z_W      = 19;   // signed Q2.16 angle accumulator
    localparam int ANG_W    = 18;   // unsigned Q2.16 clamped angle
    localparam int PULSE_W  = 16;
    localparam int HOME_W   = 16;
    localparam int STEPS_W  = 16;
    localparam int SLOPE_W  = 24;
    localparam int HALF_W   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_HOME   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_HOME  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEPS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_STEPS = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SLOPE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SLOPE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_W     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_H     = 4'd7;

    // Reset values of the configuration registers.
    localparam logic [HOME_W-1:0]  HOME_RST  = 16'd6000;
    localparam logic [STEPS_W-1:0] STEPS_RST = 16'd2590;
    localparam logic [SLOPE_W-1:0] SLOPE_RST = 24'd0;
    localparam logic [HALF_W-1:0]  HALF_W_RST = 12'd160;
    localparam logic [HALF_W-1:0]  HALF_H_RST = 12'd120;

    // 1.0 in Q.24, the starting x of the vectoring rotation.
    localparam logic signed [CORDIC_W-1:0] X_INIT = 44'sd16777216;

    // One item travelling down the chain of rotation cells.
    typedef struct packed {
        logic                       valid;
        logic                       sub;    // subtract the angle term from home
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
    } t_cell;

    // atan(2^-i) in Q2.16, rounded to nearest.
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/pixel_to_servo_pulse_unit.sv
// Top level of the pixel-to-servo pulse block: config registers, two axis pipelines.
// Depends on ptsp_pkg, ptsp_front, ptsp_cordic_cell, ptsp_back.
//
// Converts a target pixel into pan and tilt servo pulses (quarter microseconds).
// A fully pipelined datapath takes one pixel every clock: busy is never raised,
// and each item yields one result, registered through the front end, the rotation
// cells and the back end, shown on o_pan_pulse/o_tilt_pulse for one cycle with o_valid high.
// The receiver cannot stall, so it must take each result in the cycle it shows.
// Datapath order: offset and tangent multiply, then the chain of CORDIC rotation
// cells, each registered (the chain of cells sets the depth), then angle scaling and
// saturation. Configuration writes are taken every cycle (o_cfg_ready is high);
// write only while no item is in flight.
module pixel_to_servo_pulse_unit #(
    parameter int CORDIC_STAGES = ptsp_pkg::CORDIC_STAGES_DEF,
    parameter int PIXEL_BITS    = ptsp_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              start,
    output logic                              busy,
    input  logic [PIXEL_BITS-1:0]             i_pixel_x,
    input  logic [PIXEL_BITS-1:0]             i_pixel_y,
    // results
    output logic                              o_valid,
    output logic [ptsp_pkg::PULSE_W-1:0]      o_pan_pulse,
    output logic [ptsp_pkg::PULSE_W-1:0]      o_tilt_pulse,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ptsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int LATENCY = CORDIC_STAGES + 4;

    // ---- configuration registers ----
    logic [ptsp_pkg::HOME_W-1:0]  r_pan_home, r_tilt_home;
    logic [ptsp_pkg::STEPS_W-1:0] r_pan_steps, r_tilt_steps;
    logic [ptsp_pkg::SLOPE_W-1:0] r_x_slope, r_y_slope;
    logic [ptsp_pkg::HALF_W-1:0]  r_half_w, r_half_h;

    logic cfg_we;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // Pipeline never backs up, so an item goes in whenever start is seen.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_home   <= ptsp_pkg::HOME_RST;
            r_tilt_home  <= ptsp_pkg::HOME_RST;
            r_pan_steps  <= ptsp_pkg::STEPS_RST;
            r_tilt_steps <= ptsp_pkg::STEPS_RST;
            r_x_slope    <= ptsp_pkg::SLOPE_RST;
            r_y_slope    <= ptsp_pkg::SLOPE_RST;
            r_half_w     <= ptsp_pkg::HALF_W_RST;
            r_half_h     <= ptsp_pkg::HALF_H_RST;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                ptsp_pkg::CFG_PAN_HOME:   r_pan_home   <= i_cfg_data[ptsp_pkg::HOME_W-1:0];
                ptsp_pkg::CFG_TILT_HOME:  r_tilt_home  <= i_cfg_data[ptsp_pkg::HOME_W-1:0];
                ptsp_pkg::CFG_PAN_STEPS:  r_pan_steps  <= i_cfg_data[ptsp_pkg::STEPS_W-1:0];
                ptsp_pkg::CFG_TILT_STEPS: r_tilt_steps <= i_cfg_data[ptsp_pkg::STEPS_W-1:0];
                ptsp_pkg::CFG_X_SLOPE:    r_x_slope    <= i_cfg_data[ptsp_pkg::SLOPE_W-1:0];
                ptsp_pkg::CFG_Y_SLOPE:    r_y_slope    <= i_cfg_data[ptsp_pkg::SLOPE_W-1:0];
                ptsp_pkg::CFG_HALF_W:     r_half_w     <= i_cfg_data[ptsp_pkg::HALF_W-1:0];
                ptsp_pkg::CFG_HALF_H:     r_half_h     <= i_cfg_data[ptsp_pkg::HALF_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---- front ends: pan adds on the near (left) side, tilt subtracts on near (upper) ----
    ptsp_pkg::t_cell pan_link  [CORDIC_STAGES+1];
    ptsp_pkg::t_cell tilt_link [CORDIC_STAGES+1];

    ptsp_front #(.PIXEL_BITS(PIXEL_BITS), .NEAR_ADDS(1'b1)) u_front_pan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel_x),
        .i_half  (r_half_w),
        .i_slope (r_x_slope),
        .o_cell  (pan_link[0])
    );

    ptsp_front #(.PIXEL_BITS(PIXEL_BITS), .NEAR_ADDS(1'b0)) u_front_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel_y),
        .i_half  (r_half_h),
        .i_slope (r_y_slope),
        .o_cell  (tilt_link[0])
    );

    // ---- chains of rotation cells, one iteration per cell ----
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ptsp_cordic_cell #(.STAGE(g)) u_pan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (pan_link[g]),
            .o_cell  (pan_link[g+1])
        );
        ptsp_cordic_cell #(.STAGE(g)) u_tilt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (tilt_link[g]),
            .o_cell  (tilt_link[g+1])
        );
    end

    // ---- back ends ----
    logic pan_valid, tilt_valid;

    ptsp_back u_back_pan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (pan_link[CORDIC_STAGES]),
        .i_home  (r_pan_home),
        .i_steps (r_pan_steps),
        .o_valid (pan_valid),
        .o_pulse (o_pan_pulse)
    );

    ptsp_back u_back_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (tilt_link[CORDIC_STAGES]),
        .i_home  (r_tilt_home),
        .i_steps (r_tilt_steps),
        .o_valid (tilt_valid),
        .o_pulse (o_tilt_pulse)
    );

    // Both axes run in lockstep; the strobe is their agreement.
    assign o_valid = pan_valid & tilt_valid;

endmodule

FILE: hdl/ptsp_front.sv
// Per-axis front end: offset from the image half size, then tangent = offset * slope.
// Depends on ptsp_pkg; feeds the first rotation cell.
module ptsp_front #(
    parameter int   PIXEL_BITS = ptsp_pkg::PIXEL_BITS_DEF,
    parameter logic NEAR_ADDS  = 1'b1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [PIXEL_BITS-1:0]         i_pixel,
    input  logic [ptsp_pkg::HALF_W-1:0]   i_half,
    input  logic [ptsp_pkg::SLOPE_W-1:0]  i_slope,
    output ptsp_pkg::t_cell               o_cell
);
    localparam int OW = (PIXEL_BITS > ptsp_pkg::HALF_W) ? PIXEL_BITS : ptsp_pkg::HALF_W;
    localparam int TW = OW + ptsp_pkg::SLOPE_W;

    logic          r_v1, r_v2;
    logic          r_sub1, r_sub2;
    logic [OW-1:0] r_d;
    logic [TW-1:0] r_t;

    logic [OW-1:0] p_ext, h_ext;
    logic          near;

    assign p_ext = OW'(i_pixel);
    assign h_ext = OW'(i_half);
    assign near  = (p_ext <= h_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_d    <= near ? (h_ext - p_ext) : (p_ext - h_ext);
        r_sub1 <= (near != NEAR_ADDS);
        r_t    <= TW'(r_d) * TW'(i_slope);
        r_sub2 <= r_sub1;
    end

    always_comb begin
        o_cell.valid = r_v2;
        o_cell.sub   = r_sub2;
        o_cell.x     = ptsp_pkg::X_INIT;
        o_cell.y     = signed'({{(ptsp_pkg::CORDIC_W - TW){1'b0}}, r_t});
        o_cell.z     = '0;
    end

endmodule

FILE: hdl/ptsp_cordic_cell.sv
// One vectoring CORDIC iteration with a fixed shift, registered.
// Depends on ptsp_pkg (cell struct, arctangent table).
module ptsp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptsp_pkg::t_cell i_cell,
    output ptsp_pkg::t_cell o_cell
);
    ptsp_pkg::t_cell               r_cell;
    logic signed [ptsp_pkg::CORDIC_W-1:0] dx, dy;
    logic signed [ptsp_pkg::Z_W-1:0]      da;

    assign dx = i_cell.y >>> STAGE;
    assign dy = i_cell.x >>> STAGE;
    assign da = signed'(ptsp_pkg::Z_W'(ptsp_pkg::atan_q16(5'(STAGE))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= i_cell.valid;
        end
        r_cell.sub <= i_cell.sub;
        // rotate toward y = 0
        if (!i_cell.y[ptsp_pkg::CORDIC_W-1]) begin
            r_cell.x <= i_cell.x + dx;
            r_cell.y <= i_cell.y - dy;
            r_cell.z <= i_cell.z + da;
        end else begin
            r_cell.x <= i_cell.x - dx;
            r_cell.y <= i_cell.y + dy;
            r_cell.z <= i_cell.z - da;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: hdl/ptsp_back.sv
// Per-axis back end: clamp angle, scale by steps per radian, add to or subtract from home,
// truncate and saturate. Depends on ptsp_pkg.
module ptsp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptsp_pkg::t_cell               i_cell,
    input  logic [ptsp_pkg::HOME_W-1:0]   i_home,
    input  logic [ptsp_pkg::STEPS_W-1:0]  i_steps,
    output logic                          o_valid,
    output logic [ptsp_pkg::PULSE_W-1:0]  o_pulse
);
    localparam int PW = ptsp_pkg::ANG_W + ptsp_pkg::STEPS_W;   // 34-bit product
    localparam int SW = PW + 2;                                  // signed sum

    logic                        r_v1, r_v2;
    logic                        r_sub;
    logic [PW-1:0]               r_prod;
    logic [ptsp_pkg::PULSE_W-1:0] r_pulse;

    logic [ptsp_pkg::ANG_W-1:0] ang;
    logic signed [SW-1:0]       base, prod_s, sum;
    logic [ptsp_pkg::PULSE_W-1:0] pulse;

    // Negative angles clamp to zero; a non-negative 19-bit z never exceeds the top.
    assign ang = i_cell.z[ptsp_pkg::Z_W-1] ? '0 : i_cell.z[ptsp_pkg::ANG_W-1:0];

    assign base   = signed'({{(SW - ptsp_pkg::HOME_W - 16){1'b0}}, i_home, 16'd0});
    assign prod_s = signed'({2'b00, r_prod});
    assign sum    = r_sub ? (base - prod_s) : (base + prod_s);

    always_comb begin
        if (sum[SW-1]) begin
            pulse = '0;
        end else if (|sum[SW-1:32]) begin
            pulse = '1;
        end else begin
            pulse = sum[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cell.valid;
            r_v2 <= r_v1;
        end
        r_prod  <= PW'(ang) * PW'(i_steps);
        r_sub   <= i_cell.sub;
        r_pulse <= pulse;
    end

    assign o_valid = r_v2;
    assign o_pulse = r_pulse;

endmodule

FILE: hdl/ptsp_checker.sv
// Port-level checks on the pixel-to-servo pulse block, bound to its top level.
// Depends on pixel_to_servo_pulse_unit for the bind target.
module ptsp_checker #(
    parameter int LATENCY = ptsp_pkg::CORDIC_STAGES_DEF + 4
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    // Every accepted item gives its result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted item produced no result");

    // No result without an item accepted one latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // Reset flushes anything in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule

bind pixel_to_servo_pulse_unit ptsp_checker #(.LATENCY(LATENCY)) u_ptsp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

FILE: tb/tb_pixel_to_servo_pulse_unit.sv
// Self-checking testbench for pixel_to_servo_pulse_unit: directed corners, then random traffic.
// Depends on ptsp_pkg and the RTL under hdl/; it carries its own pan/tilt pulse predictor.
module tb_pixel_to_servo_pulse_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W        = ptsp_pkg::PIXEL_BITS_DEF;
    localparam int CORDIC_DEPTH = ptsp_pkg::CORDIC_STAGES_DEF;
    localparam int PULSE_W      = ptsp_pkg::PULSE_W;
    localparam int HOME_W       = ptsp_pkg::HOME_W;
    localparam int STEPS_W      = ptsp_pkg::STEPS_W;
    localparam int SLOPE_W      = ptsp_pkg::SLOPE_W;
    localparam int HALF_W       = ptsp_pkg::HALF_W;
    localparam int ANG_W        = ptsp_pkg::ANG_W;
    localparam int CFG_IDX_W    = ptsp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ptsp_pkg::CFG_DATA_W;
    // start sampled -> result strobe
    localparam int LATENCY      = CORDIC_DEPTH + 4;
    // cycles with no item, no result and no register write before we give up
    localparam int STALL_LIMIT  = 500;

    // atan(2^-i) in Q2.16; entries past the table are zero
    localparam longint ATAN_Q16 [0:17] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [PULSE_W-1:0] pan;
        logic [PULSE_W-1:0] tilt;
    } t_pulse_pair;

    typedef struct packed {
        logic [HOME_W-1:0]  pan_home;
        logic [HOME_W-1:0]  tilt_home;
        logic [STEPS_W-1:0] pan_steps;
        logic [STEPS_W-1:0] tilt_steps;
        logic [SLOPE_W-1:0] x_slope;
        logic [SLOPE_W-1:0] y_slope;
        logic [HALF_W-1:0]  half_w;
        logic [HALF_W-1:0]  half_h;
    } t_servo_setup;

    // ------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic [PIX_W-1:0]       i_pixel_x   = '0;
    logic [PIX_W-1:0]       i_pixel_y   = '0;
    logic                   o_valid;
    logic [PULSE_W-1:0]     o_pan_pulse;
    logic [PULSE_W-1:0]     o_tilt_pulse;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    pixel_to_servo_pulse_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_valid      (o_valid),
        .o_pan_pulse  (o_pan_pulse),
        .o_tilt_pulse (o_tilt_pulse),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of the setup registers, pulses in flight
    // ------------------------------------------------------------------
    t_servo_setup  shadow_setup;
    t_pulse_pair   pending_pulses[$];
    int unsigned   mismatches  = 0;
    int unsigned   stall_cycles = 0;
    bit            gaps_on     = 1'b1;

    // Vectoring rotation of (1.0, tan) down to the x axis; returns the
    // accumulated angle clamped to unsigned Q2.16.
    function automatic logic [ANG_W-1:0] vector_angle(input longint tan_q24);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(1) << 24;
        y = tan_q24;
        z = 0;
        for (int i = 0; i < CORDIC_DEPTH; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ((i < 18) ? ATAN_Q16[i] : 0);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ((i < 18) ? ATAN_Q16[i] : 0);
            end
        end
        if (z < 0)
            z = 0;
        if (z > 262143)
            z = 262143;
        return z[ANG_W-1:0];
    endfunction

    // One axis: offset from the half line, tangent, angle, scaled and
    // added to or taken from home, truncated and saturated.
    function automatic logic [PULSE_W-1:0] servo_pulse(
        input logic [PIX_W-1:0]   pix,
        input logic [HALF_W-1:0]  half,
        input logic [SLOPE_W-1:0] slope,
        input logic [HOME_W-1:0]  home,
        input logic [STEPS_W-1:0] steps,
        input bit                 near_adds
    );
        bit     near;
        longint offset;
        longint prod;
        longint sum;
        logic [ANG_W-1:0] ang;
        near   = (longint'(pix) <= longint'(half));
        offset = near ? longint'(half) - longint'(pix) : longint'(pix) - longint'(half);
        ang    = vector_angle(offset * longint'(slope));
        prod   = longint'(ang) * longint'(steps);
        sum    = longint'(home) << 16;
        sum    = (near == near_adds) ? sum + prod : sum - prod;
        if (sum < 0)
            return '0;
        sum = sum >>> 16;
        if (sum > 65535)
            sum = 65535;
        return sum[PULSE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Monitor: all sampling happens here at the rising edge, so the register
    // copy, the expected pulses and the result check see pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pulse_pair want;
        if (!i_rst_n) begin
            shadow_setup.pan_home   <= ptsp_pkg::HOME_RST;
            shadow_setup.tilt_home  <= ptsp_pkg::HOME_RST;
            shadow_setup.pan_steps  <= ptsp_pkg::STEPS_RST;
            shadow_setup.tilt_steps <= ptsp_pkg::STEPS_RST;
            shadow_setup.x_slope    <= ptsp_pkg::SLOPE_RST;
            shadow_setup.y_slope    <= ptsp_pkg::SLOPE_RST;
            shadow_setup.half_w     <= ptsp_pkg::HALF_W_RST;
            shadow_setup.half_h     <= ptsp_pkg::HALF_H_RST;
        end else begin
            // writes land after this edge; items are never sent in the same cycle
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ptsp_pkg::CFG_PAN_HOME:
                        shadow_setup.pan_home   <= i_cfg_data[HOME_W-1:0];
                    ptsp_pkg::CFG_TILT_HOME:
                        shadow_setup.tilt_home  <= i_cfg_data[HOME_W-1:0];
                    ptsp_pkg::CFG_PAN_STEPS:
                        shadow_setup.pan_steps  <= i_cfg_data[STEPS_W-1:0];
                    ptsp_pkg::CFG_TILT_STEPS:
                        shadow_setup.tilt_steps <= i_cfg_data[STEPS_W-1:0];
                    ptsp_pkg::CFG_X_SLOPE:
                        shadow_setup.x_slope    <= i_cfg_data[SLOPE_W-1:0];
                    ptsp_pkg::CFG_Y_SLOPE:
                        shadow_setup.y_slope    <= i_cfg_data[SLOPE_W-1:0];
                    ptsp_pkg::CFG_HALF_W:
                        shadow_setup.half_w     <= i_cfg_data[HALF_W-1:0];
                    ptsp_pkg::CFG_HALF_H:
                        shadow_setup.half_h     <= i_cfg_data[HALF_W-1:0];
                    default: ;      // unmapped index, no effect
                endcase
            end
            if (start && !busy) begin
                want.px   = i_pixel_x;
                want.py   = i_pixel_y;
                // pan: left of center adds; tilt: above center subtracts
                want.pan  = servo_pulse(i_pixel_x, shadow_setup.half_w, shadow_setup.x_slope,
                                        shadow_setup.pan_home, shadow_setup.pan_steps, 1'b1);
                want.tilt = servo_pulse(i_pixel_y, shadow_setup.half_h, shadow_setup.y_slope,
                                        shadow_setup.tilt_home, shadow_setup.tilt_steps, 1'b0);
                pending_pulses.push_back(want);
            end
            if (o_valid) begin
                if (pending_pulses.size() == 0) begin
                    $display("%0t: unexpected result pan=%0d tilt=%0d",
                             $time, o_pan_pulse, o_tilt_pulse);
                    mismatches++;
                end else begin
                    want = pending_pulses.pop_front();
                    if (o_pan_pulse !== want.pan) begin
                        $display("%0t: pan_pulse (x=%0d) expected %0d, got %0d",
                                 $time, want.px, want.pan, o_pan_pulse);
                        mismatches++;
                    end
                    if (o_tilt_pulse !== want.tilt) begin
                        $display("%0t: tilt_pulse (y=%0d) expected %0d, got %0d",
                                 $time, want.py, want.tilt, o_tilt_pulse);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: any item, result or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One item; start stays high across back-to-back items.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold the sender off until every pulse in flight has come back.
    task automatic wait_pipeline_empty();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_pulses.size() != 0);
    endtask

    // Leaves valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all eight registers; unused upper data bits carry junk.
    task automatic load_setup(input t_servo_setup s);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(ptsp_pkg::CFG_PAN_HOME,   {junk[23:16], s.pan_home});
        write_reg(ptsp_pkg::CFG_TILT_HOME,  {junk[15:8],  s.tilt_home});
        write_reg(ptsp_pkg::CFG_PAN_STEPS,  {junk[7:0],   s.pan_steps});
        write_reg(ptsp_pkg::CFG_TILT_STEPS, {junk[19:12], s.tilt_steps});
        write_reg(ptsp_pkg::CFG_X_SLOPE,    s.x_slope);
        write_reg(ptsp_pkg::CFG_Y_SLOPE,    s.y_slope);
        write_reg(ptsp_pkg::CFG_HALF_W,     {junk[23:12], s.half_w});
        write_reg(ptsp_pkg::CFG_HALF_H,     {junk[11:0],  s.half_h});
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly camera-like values, with a fair share of the extremes.
    function automatic t_servo_setup random_setup();
        t_servo_setup s;
        int unsigned  pick;
        pick = $urandom_range(0, 5);
        s.pan_home   = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom) : 16'($urandom_range(2000, 10000));
        pick = $urandom_range(0, 5);
        s.tilt_home  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom) : 16'($urandom_range(2000, 10000));
        pick = $urandom_range(0, 5);
        s.pan_steps  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom) : 16'($urandom_range(1000, 6000));
        pick = $urandom_range(0, 5);
        s.tilt_steps = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom) : 16'($urandom_range(1000, 6000));
        pick = $urandom_range(0, 5);
        s.x_slope    = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
                       (pick == 2) ? 24'($urandom) : 24'($urandom_range(1000, 300000));
        pick = $urandom_range(0, 5);
        s.y_slope    = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
                       (pick == 2) ? 24'($urandom) : 24'($urandom_range(1000, 300000));
        pick = $urandom_range(0, 7);
        s.half_w     = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF :
                       (pick == 2) ? 12'd2048 : 12'($urandom_range(1, 2048));
        pick = $urandom_range(0, 7);
        s.half_h     = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF :
                       (pick == 2) ? 12'd1 : 12'($urandom_range(1, 2048));
        return s;
    endfunction

    // Coordinate biased into the image, onto the center line, or anywhere.
    function automatic logic [PIX_W-1:0] pick_coord(input logic [HALF_W-1:0] half);
        int unsigned sel;
        int unsigned span;
        sel  = $urandom_range(0, 9);
        span = (2 * half > 4095) ? 4095 : 2 * half;
        if (sel < 7)
            return PIX_W'($urandom_range(0, span));
        else if (sel == 7)
            return PIX_W'(half + $urandom_range(0, 2) - 1);     // center line and neighbors
        else
            return PIX_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset setup: zero slopes, so both pulses sit at home for any pixel.
    task automatic test_reset_setup();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd161, 12'd121);
        send_pixel(12'hFFF, 12'hFFF);
    endtask

    // Saturation both ways, widest tangents, zero steps, odd half sizes.
    task automatic test_corner_setups();
        t_servo_setup s;
        wait_pipeline_empty();
        s = '{pan_home: 16'd0, tilt_home: 16'hFFFF, pan_steps: 16'hFFFF,
              tilt_steps: 16'hFFFF, x_slope: 24'hFFFFFF, y_slope: 24'hFFFFFF,
              half_w: 12'd2048, half_h: 12'd0};
        load_setup(s);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd2048, 12'd1);
        send_pixel(12'd2049, 12'd0);

        wait_pipeline_empty();
        s = '{pan_home: 16'hFFFF, tilt_home: 16'd0, pan_steps: 16'hFFFF,
              tilt_steps: 16'hFFFF, x_slope: 24'd52429, y_slope: 24'd52429,
              half_w: 12'd160, half_h: 12'd120};
        load_setup(s);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd159, 12'd119);
        send_pixel(12'd161, 12'd121);
        send_pixel(12'hFFF, 12'hFFF);

        // zero steps: angle is computed but never reaches the pulse
        wait_pipeline_empty();
        s = '{pan_home: 16'd1234, tilt_home: 16'd4321, pan_steps: 16'd0,
              tilt_steps: 16'd0, x_slope: 24'hFFFFFF, y_slope: 24'hFFFFFF,
              half_w: 12'hFFF, half_h: 12'd1};
        load_setup(s);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd7, 12'hFFF);
    endtask

    // Writes to indexes past the register map must leave the setup alone.
    task automatic test_unmapped_index();
        wait_pipeline_empty();
        for (int idx = 8; idx < 16; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'd1000, 12'd3);
        send_pixel(12'($urandom), 12'($urandom));
    endtask

    // Random setups, each followed by a burst of items; the last phases
    // run without sender gaps.
    task automatic test_random_traffic();
        t_servo_setup s;
        int unsigned  n_items;
        for (int phase = 0; phase < 10; phase++) begin
            wait_pipeline_empty();
            s = random_setup();
            load_setup(s);
            gaps_on = (phase < 8);
            n_items = $urandom_range(100, 160);
            for (int k = 0; k < n_items; k++)
                send_pixel(pick_coord(s.half_w), pick_coord(s.half_h));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_setup();
        test_corner_setups();
        test_unmapped_index();
        test_random_traffic();

        // drain, then give any stray strobe time to show up
        wait_pipeline_empty();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_pulses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
